[hw/rtl/rmsdb_pkg.sv]
// rmsdb_pkg: shared types, constants and codes for the RMS dB level meter.
// No dependencies.
`timescale 1ns / 1ps

package rmsdb_pkg;

    localparam int DEF_MAX_POINTS  = 2048;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int LEVEL_W     = 16;
    localparam int IDX_W       = 11;
    localparam int PCOUNT_W    = 12;
    localparam int SCOUNT_W    = 17;
    localparam int SUM_W       = 48;

    localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_POINT = 1'b1;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    // log10(2)/3 in Q0.16
    localparam logic [12:0] LOG_SCALE = 13'd6576;

    // Jobs for the shared unit
    typedef struct packed {
        logic        start_log;
        logic        start_sqrt;
        logic        start_div;
    } unit_cmd_t;

    typedef struct packed {
        logic        busy;
        logic        done;
    } unit_sts_t;

endpackage

[hw/rtl/rmsdb_unit.sv]
// rmsdb_unit: shared iterative unit for log2 (repeated squaring), integer square
// root (two bits a step) and restoring division (one bit a step). Uses rmsdb_pkg.
`timescale 1ns / 1ps

module rmsdb_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rmsdb_pkg::unit_cmd_t cmd,
    input  logic [63:0]          op_a,
    input  logic [63:0]          op_b,
    output rmsdb_pkg::unit_sts_t sts,
    output logic [63:0]          result
);
    import rmsdb_pkg::*;

    typedef enum logic [3:0]
    {
        U_IDLE = 4'b0001,
        U_LOG  = 4'b0010,
        U_SQRT = 4'b0100,
        U_DIV  = 4'b1000
    } ustate_t;

    ustate_t     state_reg, state_next;
    logic [6:0]  step_reg, step_next;
    logic [63:0] x_reg, x_next;       // log mantissa / sqrt remainder / div remainder
    logic [63:0] r_reg, r_next;       // result accumulator
    logic [63:0] b_reg, b_next;       // sqrt bit / divisor
    logic        done_reg, done_next;

    logic [63:0] sq;
    logic [64:0] trial;
    logic [64:0] rem_sh;

    assign sq = x_reg[31:0] * x_reg[31:0];

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        done_next  = 1'b0;
        trial      = '0;
        rem_sh     = '0;
        case (state_reg)
            U_IDLE:
            begin
                if (cmd.start_log)
                begin
                    // op_a: mantissa normalised to Q1.30, r holds fraction
                    x_next     = op_a;
                    r_next     = '0;
                    step_next  = 7'd16;
                    state_next = U_LOG;
                end
                else if (cmd.start_sqrt)
                begin
                    x_next     = op_a;
                    r_next     = '0;
                    b_next     = 64'd1 << 62;
                    step_next  = 7'd32;
                    state_next = U_SQRT;
                end
                else if (cmd.start_div)
                begin
                    x_next     = '0;
                    r_next     = op_a;   // dividend, shifted out msb first
                    b_next     = op_b;
                    step_next  = 7'd64;
                    state_next = U_DIV;
                end
            end
            U_LOG:
            begin
                // one squaring per step, one fraction bit out
                if (sq[61:30] >= 32'h8000_0000)
                begin
                    x_next = {32'd0, 1'b0, sq[61:31]};
                    r_next = {r_reg[62:0], 1'b1};
                end
                else
                begin
                    x_next = {32'd0, sq[61:30]};
                    r_next = {r_reg[62:0], 1'b0};
                end
                step_next = step_reg - 7'd1;
                if (step_reg == 7'd1)
                begin
                    state_next = U_IDLE;
                    done_next  = 1'b1;
                end
            end
            U_SQRT:
            begin
                trial = {1'b0, r_reg} + {1'b0, b_reg};
                if ({1'b0, x_reg} >= trial)
                begin
                    x_next = x_reg - trial[63:0];
                    r_next = (r_reg >> 1) + b_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                b_next    = b_reg >> 2;
                step_next = step_reg - 7'd1;
                if (step_reg == 7'd1)
                begin
                    state_next = U_IDLE;
                    done_next  = 1'b1;
                end
            end
            U_DIV:
            begin
                rem_sh = {x_reg, r_reg[63]};
                if (rem_sh >= {1'b0, b_reg})
                begin
                    x_next = rem_sh[63:0] - b_reg;
                    r_next = {r_reg[62:0], 1'b1};
                end
                else
                begin
                    x_next = rem_sh[63:0];
                    r_next = {r_reg[62:0], 1'b0};
                end
                step_next = step_reg - 7'd1;
                if (step_reg == 7'd1)
                begin
                    state_next = U_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign sts.busy = (state_reg != U_IDLE);
    assign sts.done = done_reg;
    assign result   = r_reg;

`ifndef SYNTHESIS
    a_done_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> state_reg == U_IDLE)
        else $error("unit done while busy");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != U_IDLE) |=> $past(state_reg) == U_IDLE || step_reg == $past(step_reg) - 7'd1)
        else $error("unit step count skipped");
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != U_IDLE) |-> step_reg != 7'd0)
        else $error("unit running with no steps left");
`endif

endmodule

[hw/rtl/rms_db_level_meter.sv]
// rms_db_level_meter: top level, sequencer, state and point memory.
// Uses rmsdb_pkg and rmsdb_unit.
`timescale 1ns / 1ps
//
//  channel | dir | transfer when        | content
//  s_axis  | in  | tvalid & tready      | tdata {read_index, sample}, tuser operation
//  m_axis  | out | tvalid & tready      | tdata {point_written, point_index, level}
//  cfg     | in  | cfg_valid&cfg_ready  | cfg_index, cfg_data
//
//  A sample runs the log job, then square and accumulate, before the next ready; a zero
//  sample skips the log run, and an ignored sample only returns to idle. Closing a
//  point adds a division, a square root and a store. A read runs the memory read and
//  a division, skipped for an unwritten point or zero peak, then waits out any m_axis stall.
//  Reset clears the control state; the point memory holds nothing until written.
//  s_axis_tready is low while an item is in work or a result waits on m_axis;
//  cfg_ready is high only when idle with no input transfer offered.
module rms_db_level_meter
#(
    parameter int MAX_POINTS  = rmsdb_pkg::DEF_MAX_POINTS,
    parameter int SAMPLE_BITS = rmsdb_pkg::DEF_SAMPLE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample[23:0], read_index[34:24], zero pad
    input  logic [((SAMPLE_BITS + rmsdb_pkg::IDX_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // level[15:0], point_index[26:16], point_written[27]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rmsdb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmsdb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rmsdb_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [9:0]
    {
        S_IDLE  = 10'b0000000001,
        S_LOG   = 10'b0000000010,
        S_SQ    = 10'b0000000100,
        S_ACC   = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_SQRT  = 10'b0000100000,
        S_STORE = 10'b0001000000,
        S_RDMEM = 10'b0010000000,
        S_RDDIV = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [11:0]        piu_reg;
    logic [15:0]        spp_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [15:0]        scnt_reg, scnt_next;
    logic [PCOUNT_W-1:0] pcnt_reg, pcnt_next;
    logic [15:0]        peak_reg, peak_next;
    logic [5:0]         e_reg, e_next;
    logic [33:0]        v_reg, v_next;       // signed Q.16 level, then square
    logic [15:0]        pt_reg, pt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               wr_reg, wr_next;
    logic [15:0]        lvl_reg, lvl_next;
    logic [15:0]        mem_q;
    logic [15:0]        point_store [MAX_POINTS];

    unit_cmd_t   cmd;
    unit_sts_t   sts;
    logic [63:0] op_a, op_b, ures;

    rmsdb_unit u_unit
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .op_a   (op_a),
        .op_b   (op_b),
        .sts    (sts),
        .result (ures)
    );

    // sample magnitude and msb position
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS:0]   mag;
    logic [5:0]             msb;
    logic [12:0]            limit;
    logic [16:0]            nsp;
    logic [40:0]            dprod;
    logic [22:0]            d;
    logic [23:0]            t;
    logic [67:0]            vsq;

    assign raw = s_axis_tdata[SAMPLE_BITS-1:0];
    assign mag = raw[SAMPLE_BITS-1] ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};

    always_comb
    begin
        msb = '0;
        for (int i = 0; i <= SAMPLE_BITS; i++)
        begin
            if (mag[i])
            begin
                msb = 6'(i);
            end
        end
    end

    assign limit = (32'(piu_reg) > MAX_POINTS) ? 13'(MAX_POINTS) : {1'b0, piu_reg};
    assign nsp   = (spp_reg == 16'd0) ? 17'd1 : {1'b0, spp_reg};
    assign d     = 23'(((SAMPLE_BITS - 1) << 16)) - {1'b0, e_reg, ures[15:0]};
    assign dprod = d * LOG_SCALE;
    assign t     = 24'((dprod + 41'd32768) >> 16);
    assign vsq   = 68'($signed(v_reg) * $signed(v_reg));

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        scnt_next  = scnt_reg;
        pcnt_next  = pcnt_reg;
        peak_next  = peak_reg;
        e_next     = e_reg;
        v_next     = v_reg;
        pt_next    = pt_reg;
        idx_next   = idx_reg;
        wr_next    = wr_reg;
        lvl_next   = lvl_reg;
        cmd        = '0;
        op_a       = '0;
        op_b       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == OP_READ)
                    begin
                        idx_next   = s_axis_tdata[SAMPLE_BITS +: IDX_W];
                        state_next = S_RDMEM;
                    end
                    else if ({4'd0, pcnt_reg} >= {3'd0, limit})
                    begin
                        state_next = S_IDLE;
                    end
                    else if (mag == '0)
                    begin
                        v_next     = '0;
                        state_next = S_SQ;
                    end
                    else
                    begin
                        e_next     = msb;
                        cmd.start_log = 1'b1;
                        op_a       = 64'({mag, 30'd0} >> msb);
                        state_next = S_LOG;
                    end
                end
            end
            S_LOG:
            begin
                if (sts.done)
                begin
                    v_next     = 34'(34'sd65536 - $signed({10'd0, t}));
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                v_next     = 34'((vsq + 68'd32768) >> 16);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next = ({1'b0, sum_reg} + 49'(v_reg) > 49'({SUM_W{1'b1}}))
                         ? {SUM_W{1'b1}} : sum_reg + 48'(v_reg);
                scnt_next = scnt_reg + 16'd1;
                if ({1'b0, scnt_reg} + 17'd1 >= nsp)
                begin
                    cmd.start_div = 1'b1;
                    op_a       = 64'(sum_next);
                    op_b       = 64'({1'b0, scnt_reg} + 17'd1);
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (sts.done)
                begin
                    cmd.start_sqrt = 1'b1;
                    op_a       = {ures[47:0], 16'd0};
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sts.done)
                begin
                    pt_next    = (ures > 64'd65535) ? 16'hFFFF : ures[15:0];
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                if (pt_reg > peak_reg)
                begin
                    peak_next = pt_reg;
                end
                pcnt_next  = pcnt_reg + 1'b1;
                sum_next   = '0;
                scnt_next  = '0;
                state_next = S_IDLE;
            end
            S_RDMEM:
            begin
                // memory read data is registered here and is valid in S_RDDIV
                wr_next    = ({1'b0, idx_reg} < pcnt_reg) &&
                             (32'(idx_reg) < 32'(MAX_POINTS));
                state_next = S_RDDIV;
            end
            S_RDDIV:
            begin
                if (!wr_reg || peak_reg == 16'd0)
                begin
                    lvl_next   = '0;
                    state_next = S_OUT;
                end
                else if (!sts.busy && !sts.done)
                begin
                    cmd.start_div = 1'b1;
                    op_a = {32'd0, mem_q, 16'd0};
                    op_b = {48'd0, peak_reg};
                end
                else if (sts.done)
                begin
                    lvl_next   = (ures > 64'd65535) ? 16'hFFFF : ures[15:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            piu_reg   <= 12'd1800;
            spp_reg   <= 16'd1;
            sum_reg   <= '0;
            scnt_reg  <= '0;
            pcnt_reg  <= '0;
            peak_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            scnt_reg  <= scnt_next;
            pcnt_reg  <= pcnt_next;
            peak_reg  <= peak_next;
            if (cfg_valid && cfg_ready && cfg_index == REG_POINTS_IN_USE)
            begin
                piu_reg <= cfg_data[11:0];
            end
            if (cfg_valid && cfg_ready && cfg_index == REG_SAMPLES_PER_POINT)
            begin
                spp_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg   <= e_next;
        v_reg   <= v_next;
        pt_reg  <= pt_next;
        idx_reg <= idx_next;
        wr_reg  <= wr_next;
        lvl_reg <= lvl_next;
    end

    // point memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == S_STORE)
        begin
            point_store[AW'(pcnt_reg)] <= pt_reg;
        end
        mem_q <= point_store[AW'(idx_reg)];
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE) && !s_axis_tvalid;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {4'd0, wr_reg, idx_reg, lvl_reg};

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.busy |-> !s_axis_tready)
        else $error("input taken while unit busy");
    a_level_zero_unwritten: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !wr_reg) |-> lvl_reg == 16'd0)
        else $error("level on unwritten point");
    a_pcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pcnt_reg) <= MAX_POINTS)
        else $error("point count past memory");
`endif

endmodule

[test/rms_db_level_meter_tb.sv]
// rms_db_level_meter_tb: self-checking testbench for the RMS dB level meter.
// Predicts read results in a scoreboard class and drives the streams with tasks.
// Depends on rmsdb_pkg and rms_db_level_meter.
`timescale 1ns / 1ps

module rms_db_level_meter_tb;
    import rmsdb_pkg::*;

    localparam int NPTS = 2048;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE = 150;

    typedef struct {
        bit [15:0] level;
        bit [10:0] index;
        bit        written;
    } level_read_t;

    // Level meter model: state, registers and the queue of pending read results
    class level_board;
        bit [11:0]   pts_in_use;
        bit [15:0]   smp_per_pt;
        longint unsigned sum;
        bit [16:0]   smp_cnt;
        bit [11:0]   pt_cnt;
        bit [15:0]   peak;
        bit [15:0]   pts [NPTS];
        level_read_t pending [$];
        int          errors;

        function new();
            pts_in_use = 12'd1800;
            smp_per_pt = 16'd1;
            sum = 0;
            smp_cnt = 0;
            pt_cnt = 0;
            peak = 0;
            errors = 0;
        endfunction

        function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [15:0] val);
            if (idx == REG_POINTS_IN_USE)
                pts_in_use = val[11:0];
            else
                smp_per_pt = val;
        endfunction

        // log2 in Q.16 by repeated squaring of the normalised mantissa
        function longint unsigned log2_fix(longint unsigned a);
            int e;
            longint unsigned x;
            longint unsigned fr;
            e = 0;
            fr = 0;
            while (e < 63 && (a >> (e + 1)) != 0)
                e++;
            x = (e <= 30) ? (a << (30 - e)) : (a >> (e - 30));
            for (int i = 0; i < 16; i++)
            begin
                x = (x * x) >> 30;
                fr = fr << 1;
                if (x >= (64'd1 << 31))
                begin
                    fr = fr | 1;
                    x = x >> 1;
                end
            end
            return (longint'(e) << 16) | fr;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // squared dB-scale value of one sample, Q.16
        function longint unsigned level_sq(bit [23:0] s);
            longint unsigned a;
            longint unsigned d;
            longint unsigned t;
            longint unsigned m;
            if (s == 0)
                return 0;
            a = s[23] ? (64'd1 << 24) - s : s;
            d = 64'd23 << 16;
            t = log2_fix(a);
            d = (t <= d) ? d - t : 0;
            t = (d * 6576 + 32768) >> 16;
            m = (t <= 65536) ? 65536 - t : t - 65536;
            return (m * m + 32768) >> 16;
        endfunction

        // note an accepted input transfer
        function void note_input(bit op, bit [23:0] s, bit [10:0] idx);
            int lim;
            int n;
            longint unsigned pt;
            level_read_t r;
            if (op == OP_FEED)
            begin
                lim = (pts_in_use > NPTS) ? NPTS : pts_in_use;
                if (pt_cnt >= lim)
                    return;
                n = (smp_per_pt == 0) ? 1 : smp_per_pt;
                sum = sum + level_sq(s);
                if (sum > ((64'd1 << 48) - 1))
                    sum = (64'd1 << 48) - 1;
                smp_cnt = smp_cnt + 1;
                if (smp_cnt >= n)
                begin
                    pt = int_sqrt((sum / smp_cnt) << 16);
                    if (pt > 65535)
                        pt = 65535;
                    if (pt > peak)
                        peak = 16'(pt);
                    pts[pt_cnt % NPTS] = 16'(pt);
                    pt_cnt = pt_cnt + 1;
                    sum = 0;
                    smp_cnt = 0;
                end
                return;
            end
            r.level = 0;
            r.index = idx;
            r.written = 0;
            if (idx < pt_cnt)
            begin
                r.written = 1;
                if (peak != 0)
                begin
                    pt = (longint'(pts[idx]) << 16) / peak;
                    r.level = (pt > 65535) ? 16'hFFFF : 16'(pt);
                end
            end
            pending.push_back(r);
        endfunction

        // compare one output transfer with the oldest pending read
        function void check_result(bit [31:0] d);
            level_read_t r;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer: tdata %h", d);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (d[15:0] != r.level)
            begin
                $error("level: expected %0d, actual %0d", r.level, d[15:0]);
                errors++;
            end
            if (d[26:16] != r.index)
            begin
                $error("point_index: expected %0d, actual %0d", r.index, d[26:16]);
                errors++;
            end
            if (d[27] != r.written)
            begin
                $error("point_written: expected %0d, actual %0d", r.written, d[27]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    level_board sb;
    int burst_left;
    int rx_mode;
    int rx_left;
    int idle_cycles;

    rms_db_level_meter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: stall pattern changes between always ready, random and long blocks
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ((rx_left % 32) >= 24);
        endcase
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one input transfer, then a random gap at the end of a burst
    task automatic send_item(bit op, bit [23:0] s, bit [10:0] idx);
        int gap;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {5'd0, idx, s};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(op, s, idx);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // stop sending and wait for every pending read and the tail of a sample
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [15:0] val);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // samples spread over the whole 60 dB range and beyond
    function automatic bit [23:0] pick_sample();
        bit [23:0] v;
        case ($urandom_range(0, 5))
            0: v = 24'($urandom);
            1: v = 24'h800000;
            2: v = 24'h7FFFFF;
            3: v = 24'd0;
            default:
            begin
                v = 24'(($urandom & 24'h7FFFFF) >> $urandom_range(0, 22));
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic random_items(int count, int read_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < read_pct)
                send_item(OP_READ, 24'($urandom), $urandom_range(0, 3) == 0 ?
                          11'($urandom) : 11'($urandom_range(0, sb.pt_cnt)));
            else
                send_item(OP_FEED, pick_sample(), 11'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_FEED;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_POINTS_IN_USE;
        cfg_data = '0;
        burst_left = 0;
        rx_mode = 0;
        rx_left = 0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reads before any point, zero peak, extremes of sample and index
        send_item(OP_READ, 24'd0, 11'd0);
        send_item(OP_READ, 24'hFFFFFF, 11'd2047);
        send_item(OP_FEED, 24'd0, 11'd0);
        send_item(OP_READ, 24'd0, 11'd0);
        send_item(OP_READ, 24'd0, 11'd1);
        send_item(OP_FEED, 24'd1, 11'h7FF);
        send_item(OP_FEED, 24'hFFFFFF, 11'd0);
        send_item(OP_FEED, 24'h7FFFFF, 11'd0);
        send_item(OP_FEED, 24'h800000, 11'd0);
        send_item(OP_FEED, 24'h400000, 11'd0);
        send_item(OP_FEED, 24'h000200, 11'd0);
        for (int i = 0; i < 8; i++)
            send_item(OP_READ, 24'd0, 11'(i));
        send_item(OP_READ, 24'd0, 11'd2047);

        // zero points in use: every sample ignored
        write_reg(REG_POINTS_IN_USE, 16'd0);
        send_item(OP_FEED, 24'h7FFFFF, 11'd0);
        send_item(OP_FEED, 24'h123456, 11'd0);
        send_item(OP_READ, 24'd0, 11'd7);

        // points in use above the store size, zero samples per point
        write_reg(REG_POINTS_IN_USE, 16'hFFFF);
        write_reg(REG_SAMPLES_PER_POINT, 16'd0);
        random_items(400, 25);

        // largest point size, then lowered so the point closes on the next sample
        write_reg(REG_SAMPLES_PER_POINT, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_item(OP_FEED, pick_sample(), 11'd0);
        write_reg(REG_SAMPLES_PER_POINT, 16'd3);
        send_item(OP_FEED, pick_sample(), 11'd0);
        send_item(OP_READ, 24'd0, 11'(sb.pt_cnt - 1));
        random_items(400, 25);

        write_reg(REG_POINTS_IN_USE, 16'd2048);
        write_reg(REG_SAMPLES_PER_POINT, 16'($urandom_range(1, 16)));
        random_items(400, 30);
        write_reg(REG_SAMPLES_PER_POINT, 16'd1);
        random_items(400, 20);

        // one point in use: collection stops, reads still served
        write_reg(REG_POINTS_IN_USE, 16'd1);
        random_items(300, 40);

        drain();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
